@@ sv/gstwt_pkg.sv @@
package gstwt_pkg;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CENTER,
		OP_MOVE_H,
		OP_MOVE_V
	} op_t;

	// what one axis lane does with its target on a transfer
	typedef enum logic [1:0] {
		UPD_HOLD,
		UPD_FRAME,
		UPD_CENTER,
		UPD_MOVE
	} upd_t;

	localparam logic [2:0] REG_CENTER_H     = 3'd0;
	localparam logic [2:0] REG_CENTER_V     = 3'd1;
	localparam logic [2:0] REG_LIMIT_H      = 3'd2;
	localparam logic [2:0] REG_LIMIT_V      = 3'd3;
	localparam logic [2:0] REG_LOST_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_RATE_WINDOW  = 3'd5;

	localparam logic [10:0] ANGLE_FULL  = 11'd1800;
	localparam logic [10:0] POS_RESET   = 11'd900;
	localparam logic [10:0] CENTER_RST  = 11'd900;
	localparam logic [9:0]  LIMIT_H_RST = 10'd750;
	localparam logic [9:0]  LIMIT_V_RST = 10'd600;
	localparam logic [15:0] TIMEOUT_RST = 16'd500;
	localparam logic [15:0] WINDOW_RST  = 16'd500;

	// pulse = 625 + floor(25 * t / 18), compare = 25000 - pulse
	localparam logic [15:0] PULSE_SCALE = 16'd25;
	localparam logic [14:0] CMP_BASE    = 15'd24375;
	localparam logic [16:0] RECIP_18    = 17'd116509;
	localparam int          SHIFT_18    = 21;
	localparam logic [11:0] RECIP_10    = 12'd3277;
	localparam int          SHIFT_10    = 15;

	typedef struct packed {
		logic        drive;
		logic        link_lost;
		logic [7:0]  rate;
		logic [15:0] total;
	} stat_t;

	typedef struct packed {
		logic [10:0] pos;
		logic [15:0] scaled;
		logic [7:0]  deg;
		logic [9:0]  offq;
	} lane_res_t;

	function automatic logic [10:0] lower_bound(input logic [10:0] c, input logic [9:0] l);
		logic [10:0] lo;
		lo = (c > {1'b0, l}) ? c - {1'b0, l} : 11'd0;
		return (lo > ANGLE_FULL) ? ANGLE_FULL : lo;
	endfunction

	function automatic logic [10:0] upper_bound(input logic [10:0] c, input logic [9:0] l);
		logic [11:0] hi;
		hi = {1'b0, c} + {2'b0, l};
		return (hi > {1'b0, ANGLE_FULL}) ? ANGLE_FULL : hi[10:0];
	endfunction

	function automatic logic [10:0] clamp_range(input logic [15:0] v, input logic [10:0] lo,
		input logic [10:0] hi);
		logic [10:0] r;
		if (v < {5'b0, lo}) begin
			r = lo;
		end else if (v > {5'b0, hi}) begin
			r = hi;
		end else begin
			r = v[10:0];
		end
		return r;
	endfunction

	// exact floor(v / 10) for any 11-bit v
	function automatic logic [7:0] div10(input logic [10:0] v);
		logic [22:0] p;
		p = {12'b0, v} * {11'b0, RECIP_10};
		return p[SHIFT_10 +: 8];
	endfunction

endpackage

@@ sv/gimbal_servo_target_with_timeout_unit.sv @@
// an input transfer is registered in stage one, stage two and the output register on its way to the output port
// throughput: one item per cycle when not stalled; the targets and counters update in the cycle of the transfer
// the output register and the two stages ahead of it fill bubbles while the output stalls
// reset: asynchronous, active low; targets 900, link lost, counters zero, config registers to defaults
module gimbal_servo_target_with_timeout_unit
	import gstwt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // angle_x, angle_y, delta_tenths, zero pad
	input  logic [2:0]   s_tuser,   // op, frame_valid
	output logic         m_tvalid,
	input  logic         m_tready,
	// compare_h, compare_v, drive_update, target_h, target_v, link_lost,
	// frames_per_second, frame_total, degrees_h, degrees_v, offset_h, offset_v, zero pad
	output logic [111:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [10:0] center_h_q;
	logic [10:0] center_v_q;
	logic [9:0]  limit_h_q;
	logic [9:0]  limit_v_q;
	logic [15:0] timeout_q;
	logic [15:0] window_q;

	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      rdy1;
	logic      rdy2;
	logic      rdy3;
	logic      acc;
	logic      en_s2;
	logic      en_s3;
	op_t       op;
	logic      frame_valid;
	upd_t      upd_h;
	upd_t      upd_v;
	stat_t     stat_s1;
	stat_t     stat_s2;
	lane_res_t res_h_s2;
	lane_res_t res_v_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_h_q <= CENTER_RST;
			center_v_q <= CENTER_RST;
			limit_h_q <= LIMIT_H_RST;
			limit_v_q <= LIMIT_V_RST;
			timeout_q <= TIMEOUT_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_H: center_h_q <= cfg_data[10:0];
				REG_CENTER_V: center_v_q <= cfg_data[10:0];
				REG_LIMIT_H: limit_h_q <= cfg_data[9:0];
				REG_LIMIT_V: limit_v_q <= cfg_data[9:0];
				REG_LOST_TIMEOUT: timeout_q <= cfg_data;
				REG_RATE_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// each stage moves on when the one after it is empty or moving
	assign rdy3 = !v_s3 || m_tready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign acc = s_tvalid && rdy1;
	assign en_s2 = v_s1 && rdy2;
	assign en_s3 = v_s2 && rdy3;
	assign m_tvalid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign op = op_t'(s_tuser[1:0]);
	assign frame_valid = s_tuser[2];

	always_comb begin
		case (op)
			OP_TICK: begin
				upd_h = frame_valid ? UPD_FRAME : UPD_HOLD;
				upd_v = frame_valid ? UPD_FRAME : UPD_HOLD;
			end
			OP_CENTER: begin
				upd_h = UPD_CENTER;
				upd_v = UPD_CENTER;
			end
			OP_MOVE_H: begin
				upd_h = UPD_MOVE;
				upd_v = UPD_HOLD;
			end
			OP_MOVE_V: begin
				upd_h = UPD_HOLD;
				upd_v = UPD_MOVE;
			end
			default: begin
				upd_h = UPD_HOLD;
				upd_v = UPD_HOLD;
			end
		endcase
	end

	gstwt_axis u_axis_h (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.upd    (upd_h),
		.angle  (s_tdata[15:0]),
		.delta  (s_tdata[44:32]),
		.center (center_h_q),
		.limit  (limit_h_q),
		.en_s2  (en_s2),
		.res_s2 (res_h_s2)
	);

	gstwt_axis u_axis_v (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.upd    (upd_v),
		.angle  (s_tdata[31:16]),
		.delta  (s_tdata[44:32]),
		.center (center_v_q),
		.limit  (limit_v_q),
		.en_s2  (en_s2),
		.res_s2 (res_v_s2)
	);

	gstwt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.op           (op),
		.frame_valid  (frame_valid),
		.lost_timeout (timeout_q),
		.rate_window  (window_q),
		.stat_s1      (stat_s1)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			stat_s2 <= stat_s1;
		end
	end

	gstwt_merge u_merge (
		.clk     (clk),
		.en_s3   (en_s3),
		.res_h   (res_h_s2),
		.res_v   (res_v_s2),
		.stat    (stat_s2),
		.data_s3 (m_tdata)
	);

endmodule

@@ sv/gstwt_axis.sv @@
module gstwt_axis
	import gstwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  upd_t        upd,
	input  logic [15:0] angle,
	input  logic [12:0] delta,
	input  logic [10:0] center,
	input  logic [9:0]  limit,
	input  logic        en_s2,
	output lane_res_t   res_s2
);

	logic [10:0] pos_q;
	logic [10:0] pos_s1;
	logic [10:0] pos_next;
	logic [10:0] lo;
	logic [10:0] hi;
	logic signed [14:0] sum;
	logic [15:0] moved_u;
	logic signed [12:0] diff;
	logic [10:0] mag;
	logic [7:0]  offmag;
	lane_res_t   res_next;

	always_comb begin
		lo = lower_bound(center, limit);
		hi = upper_bound(center, limit);
		sum = $signed({4'b0, pos_q}) + $signed({{2{delta[12]}}, delta});
		// a sum at or below zero becomes zero before the clamp
		moved_u = (sum <= 15'sd0) ? 16'd0 : {1'b0, sum};
		case (upd)
			UPD_FRAME: pos_next = clamp_range(angle, lo, hi);
			UPD_CENTER: pos_next = (center > ANGLE_FULL) ? ANGLE_FULL : center;
			UPD_MOVE: pos_next = clamp_range(moved_u, lo, hi);
			default: pos_next = pos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_RESET;
		end else if (acc) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_s1 <= pos_next;
		end
	end

	// center minus target, divided by ten toward zero
	always_comb begin
		diff = $signed({2'b0, center}) - $signed({2'b0, pos_s1});
		mag = diff[12] ? 11'(-diff) : diff[10:0];
		offmag = div10(mag);
		res_next.pos = pos_s1;
		res_next.scaled = {5'b0, pos_s1} * PULSE_SCALE;
		res_next.deg = div10(pos_s1);
		res_next.offq = diff[12] ? -{2'b0, offmag} : {2'b0, offmag};
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2 <= res_next;
		end
	end

endmodule

@@ sv/gstwt_ctrl.sv @@
module gstwt_ctrl
	import gstwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  op_t         op,
	input  logic        frame_valid,
	input  logic [15:0] lost_timeout,
	input  logic [15:0] rate_window,
	output stat_t       stat_s1
);

	logic [31:0] tick_q;
	logic [31:0] last_frame_q;
	logic [31:0] win_start_q;
	logic [7:0]  win_frames_q;
	logic [7:0]  rate_q;
	logic [15:0] total_q;
	logic        lost_q;

	logic [31:0] tick_n;
	logic [31:0] last_frame_n;
	logic [31:0] win_start_n;
	logic [7:0]  win_frames_n;
	logic [7:0]  rate_n;
	logic [15:0] total_n;
	logic        lost_n;
	logic        drive_n;
	logic [31:0] since_frame;
	logic [31:0] since_win;

	always_comb begin
		tick_n = tick_q;
		last_frame_n = last_frame_q;
		win_start_n = win_start_q;
		win_frames_n = win_frames_q;
		rate_n = rate_q;
		total_n = total_q;
		lost_n = lost_q;
		drive_n = 1'b1;
		since_frame = '0;
		since_win = '0;
		case (op)
			OP_TICK: begin
				tick_n = tick_q + 32'd1;
				if (frame_valid) begin
					lost_n = 1'b0;
					last_frame_n = tick_n;
					win_frames_n = win_frames_q + 8'd1;
					total_n = total_q + 16'd1;
				end
				since_frame = tick_n - last_frame_n;
				if (since_frame > {16'b0, lost_timeout}) begin
					lost_n = 1'b1;
				end
				drive_n = !lost_n;
				since_win = tick_n - win_start_q;
				if (since_win >= {16'b0, rate_window}) begin
					rate_n = {win_frames_n[6:0], 1'b0};
					win_frames_n = '0;
					win_start_n = tick_n;
				end
			end
			OP_CENTER: lost_n = 1'b1;
			default: lost_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			last_frame_q <= '0;
			win_start_q <= '0;
			win_frames_q <= '0;
			rate_q <= '0;
			total_q <= '0;
			lost_q <= 1'b1;
		end else if (acc) begin
			tick_q <= tick_n;
			last_frame_q <= last_frame_n;
			win_start_q <= win_start_n;
			win_frames_q <= win_frames_n;
			rate_q <= rate_n;
			total_q <= total_n;
			lost_q <= lost_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stat_s1.drive <= drive_n;
			stat_s1.link_lost <= lost_n;
			stat_s1.rate <= rate_n;
			stat_s1.total <= total_n;
		end
	end

endmodule

@@ sv/gstwt_merge.sv @@
module gstwt_merge
	import gstwt_pkg::*;
(
	input  logic         clk,
	input  logic         en_s3,
	input  lane_res_t    res_h,
	input  lane_res_t    res_v,
	input  stat_t        stat,
	output logic [111:0] data_s3
);

	logic [32:0]  prod_h;
	logic [32:0]  prod_v;
	logic [14:0]  cmp_h;
	logic [14:0]  cmp_v;
	logic [9:0]   offq_v;
	logic [7:0]   off_h;
	logic [7:0]   off_v;
	logic [111:0] data_next;

	function automatic logic [7:0] sat8(input logic [9:0] x);
		logic signed [9:0] s;
		logic [7:0] r;
		s = $signed(x);
		if (s > 10'sd127) begin
			r = 8'h7F;
		end else if (s < -10'sd128) begin
			r = 8'h80;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

	always_comb begin
		prod_h = {17'b0, res_h.scaled} * {16'b0, RECIP_18};
		prod_v = {17'b0, res_v.scaled} * {16'b0, RECIP_18};
		cmp_h = CMP_BASE - {3'b0, prod_h[SHIFT_18 +: 12]};
		cmp_v = CMP_BASE - {3'b0, prod_v[SHIFT_18 +: 12]};
		// vertical offset runs the other way: target minus center
		offq_v = -res_v.offq;
		off_h = sat8(res_h.offq);
		off_v = sat8(offq_v);
		data_next = {2'b0, off_v, off_h, res_v.deg, res_h.deg, stat.total, stat.rate,
			stat.link_lost, res_v.pos, res_h.pos, stat.drive, cmp_v, cmp_h};
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			data_s3 <= data_next;
		end
	end

endmodule
